// ===== hdl/wbps_pkg.sv =====
// shared types and constants of the wildcard byte pattern scanner
package wbps_pkg;

  localparam int unsigned PatternBytes = 16;
  localparam int unsigned PosW         = 32;
  localparam int unsigned AddrW        = 48;
  localparam int unsigned LenW         = 5;
  localparam int unsigned MaskW        = 16;
  localparam int unsigned CfgIdxW      = 3;
  localparam int unsigned CfgDataW     = 64;

  typedef enum logic [CfgIdxW-1:0] {
    RegPatternLow    = 3'd0,
    RegPatternHigh   = 3'd1,
    RegWildcardMask  = 3'd2,
    RegPatternLength = 3'd3,
    RegBaseAddress   = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [PatternBytes-1:0][7:0] pattern;
    logic [MaskW-1:0]             wild;
    logic [LenW-1:0]              len;
  } scan_cfg_t;

  typedef struct packed {
    logic            hit;
    logic [PosW-1:0] offset;
    logic            miss;
  } scan_item_t;

endpackage

// ===== hdl/wbps_in_if.sv =====
// input channel: one memory byte per beat
interface wbps_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// ===== hdl/wbps_out_if.sv =====
// output channel: one scan result per beat
interface wbps_out_if;
  logic        valid;
  logic        ready;
  logic        hit;
  logic [31:0] hit_offset;
  logic [47:0] hit_address;
  logic        miss_at_end;

  modport source (output valid, output hit, output hit_offset, output hit_address,
                  output miss_at_end, input ready);
  modport sink   (input valid, input hit, input hit_offset, input hit_address,
                  input miss_at_end, output ready);
endinterface

// ===== hdl/wildcard_byte_pattern_scanner.sv =====
// Wildcard byte pattern scanner: takes one memory byte per beat and returns one
// result beat per byte, reporting the first match of the configured pattern in each
// region (offset and base-relative address) or a miss on the region's last byte.
// Sustained rate is one byte per clock unless the output stalls. The cycle time is set
// by the parallel compare of the byte window against every pattern length, followed
// by the 32-bit position update; the 48-bit address add sits in its own stage behind
// a two-entry queue. Pattern registers are written through the cfg port; the user must
// write them only while the scanner is idle, which the block itself does not enforce.
module wildcard_byte_pattern_scanner #(
  parameter int unsigned PatternMax = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  wbps_in_if.sink                         in_ch,
  wbps_out_if.source                      out_ch,
  input  logic                            cfg_we_i,
  input  logic [wbps_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [wbps_pkg::CfgDataW-1:0]   cfg_data_i
);

  localparam int unsigned WinDepth =
    (PatternMax < wbps_pkg::PatternBytes) ? PatternMax : wbps_pkg::PatternBytes;

  logic [63:0]                  pattern_low_q, pattern_high_q;
  logic [wbps_pkg::MaskW-1:0]   wild_q;
  logic [wbps_pkg::LenW-1:0]    len_q;
  logic [wbps_pkg::AddrW-1:0]   base_q;

  wbps_pkg::scan_cfg_t          scan_cfg;
  wbps_pkg::scan_item_t         front_item, queue_item;
  logic                         front_valid, front_ready;
  logic                         queue_valid, queue_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_low_q  <= '0;
      pattern_high_q <= '0;
      wild_q         <= '0;
      len_q          <= wbps_pkg::LenW'(1);
      base_q         <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        wbps_pkg::RegPatternLow:    pattern_low_q  <= cfg_data_i;
        wbps_pkg::RegPatternHigh:   pattern_high_q <= cfg_data_i;
        wbps_pkg::RegWildcardMask:  wild_q         <= cfg_data_i[wbps_pkg::MaskW-1:0];
        wbps_pkg::RegPatternLength: len_q          <= cfg_data_i[wbps_pkg::LenW-1:0];
        wbps_pkg::RegBaseAddress:   base_q         <= cfg_data_i[wbps_pkg::AddrW-1:0];
        default: ;
      endcase
    end
  end

  assign scan_cfg.pattern = {pattern_high_q, pattern_low_q};
  assign scan_cfg.wild    = wild_q;
  assign scan_cfg.len     = len_q;

  wbps_front #(
    .WinDepth (WinDepth)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (scan_cfg),
    .in_ch        (in_ch),
    .item_valid_o (front_valid),
    .item_ready_i (front_ready),
    .item_o       (front_item)
  );

  wbps_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (front_valid),
    .wr_ready_o (front_ready),
    .wr_item_i  (front_item),
    .rd_valid_o (queue_valid),
    .rd_ready_i (queue_ready),
    .rd_item_o  (queue_item)
  );

  wbps_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .base_i       (base_q),
    .item_valid_i (queue_valid),
    .item_ready_o (queue_ready),
    .item_i       (queue_item),
    .out_ch       (out_ch)
  );

endmodule

// ===== hdl/wbps_front.sv =====
// front end: byte window, region position and parallel wildcard compare
module wbps_front #(
  parameter int unsigned WinDepth = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  wbps_pkg::scan_cfg_t   cfg_i,
  wbps_in_if.sink               in_ch,
  output logic                  item_valid_o,
  input  logic                  item_ready_i,
  output wbps_pkg::scan_item_t  item_o
);

  localparam int unsigned LenIdxW = (WinDepth > 1) ? $clog2(WinDepth) : 1;
  localparam logic [wbps_pkg::LenW-1:0] CapLen = wbps_pkg::LenW'(WinDepth);

  logic [WinDepth-1:0][7:0]      win_q, win_d;
  logic [wbps_pkg::PosW-1:0]     pos_q, pos_d, pos_inc;
  logic                          seen_q, seen_d;
  logic [wbps_pkg::LenW-1:0]     len_use, len_m1;
  logic [WinDepth-1:0]           len_ok;
  logic                          accept, long_enough, hit;

  assign accept       = in_ch.valid && item_ready_i;
  assign in_ch.ready  = item_ready_i;
  assign item_valid_o = in_ch.valid;

  always_comb begin
    if (cfg_i.len == '0) begin
      len_use = wbps_pkg::LenW'(1);
    end else if (cfg_i.len > CapLen) begin
      len_use = CapLen;
    end else begin
      len_use = cfg_i.len;
    end
    len_m1 = len_use - wbps_pkg::LenW'(1);
  end

  // window after the current byte shifts in, index 0 is the newest byte
  always_comb begin
    win_d[0] = in_ch.data_byte;
    for (int k = 1; k < WinDepth; k++) begin
      win_d[k] = win_q[k-1];
    end
  end

  // one compare result per possible pattern length
  always_comb begin
    for (int l = 0; l < WinDepth; l++) begin
      len_ok[l] = 1'b1;
      for (int j = 0; j < WinDepth; j++) begin
        if (j <= l) begin
          if (!cfg_i.wild[j] && (win_d[l-j] != cfg_i.pattern[j])) begin
            len_ok[l] = 1'b0;
          end
        end
      end
    end
  end

  always_comb begin
    pos_inc     = (pos_q == '1) ? pos_q : pos_q + wbps_pkg::PosW'(1);
    long_enough = pos_inc >= wbps_pkg::PosW'(len_use);
    hit         = !seen_q && long_enough && len_ok[len_m1[LenIdxW-1:0]];

    item_o.hit    = hit;
    item_o.offset = hit ? (pos_inc - wbps_pkg::PosW'(len_use)) : '0;
    item_o.miss   = in_ch.last_byte && !(seen_q || hit);

    // region end returns to the start state
    if (in_ch.last_byte) begin
      pos_d  = '0;
      seen_d = 1'b0;
    end else begin
      pos_d  = pos_inc;
      seen_d = seen_q || hit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      seen_q <= 1'b0;
    end else if (accept) begin
      pos_q  <= pos_d;
      seen_q <= seen_d;
    end
  end

  // window bytes are only compared once the region has filled them
  always_ff @(posedge clk_i) begin
    if (accept) begin
      win_q <= win_d;
    end
  end

endmodule

// ===== hdl/wbps_queue.sv =====
// two-entry queue between the front end and the address stage
module wbps_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 wr_valid_i,
  output logic                 wr_ready_o,
  input  wbps_pkg::scan_item_t wr_item_i,
  output logic                 rd_valid_o,
  input  logic                 rd_ready_i,
  output wbps_pkg::scan_item_t rd_item_o
);

  wbps_pkg::scan_item_t slot_q [2];
  logic [1:0]           count_q, count_d;
  logic                 wr_ptr_q, rd_ptr_q;
  logic                 push, pop;

  assign wr_ready_o = count_q != 2'd2;
  assign rd_valid_o = count_q != 2'd0;
  assign rd_item_o  = slot_q[rd_ptr_q];
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;

  always_comb begin
    count_d = count_q;
    if (push && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= 2'd0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= wr_item_i;
    end
  end

endmodule

// ===== hdl/wbps_back.sv =====
// back end: match address add and output register
module wbps_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [wbps_pkg::AddrW-1:0]    base_i,
  input  logic                          item_valid_i,
  output logic                          item_ready_o,
  input  wbps_pkg::scan_item_t          item_i,
  wbps_out_if.source                    out_ch
);

  logic                          valid_q;
  logic                          hit_q, miss_q;
  logic [wbps_pkg::PosW-1:0]     offset_q;
  logic [wbps_pkg::AddrW-1:0]    addr_q, addr_d;
  logic                          take;

  assign item_ready_o = !valid_q || out_ch.ready;
  assign take         = item_valid_i && item_ready_o;

  assign addr_d = item_i.hit
                ? (base_i + wbps_pkg::AddrW'(item_i.offset))
                : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (take) begin
      valid_q <= 1'b1;
    end else if (out_ch.ready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      hit_q    <= item_i.hit;
      offset_q <= item_i.offset;
      miss_q   <= item_i.miss;
      addr_q   <= addr_d;
    end
  end

  assign out_ch.valid       = valid_q;
  assign out_ch.hit         = hit_q;
  assign out_ch.hit_offset  = offset_q;
  assign out_ch.hit_address = addr_q;
  assign out_ch.miss_at_end = miss_q;

endmodule

// ===== dv/wbps_scan_checker.sv =====
// scoreboard for the pattern scanner: predicts every result beat and compares it
`timescale 1ns / 1ps
module wbps_scan_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  wbps_in_if                            in_ch,
  wbps_out_if                           out_ch,
  input  logic                          cfg_we_i,
  input  logic [wbps_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [wbps_pkg::CfgDataW-1:0] cfg_data_i,
  output int                            outstanding_o,
  output int                            fail_count_o,
  output int                            hit_count_o,
  output int                            miss_count_o
);

  typedef struct packed {
    logic                       hit;
    logic [wbps_pkg::PosW-1:0]  offset;
    logic [wbps_pkg::AddrW-1:0] address;
    logic                       miss;
  } scan_result_t;

  // recent_bytes[k] is the byte k beats back, 0 being the newest
  logic [7:0]                 recent_bytes [wbps_pkg::PatternBytes];
  logic [wbps_pkg::PosW-1:0]  region_count;
  logic                       found;
  logic [127:0]               pattern;
  logic [wbps_pkg::MaskW-1:0] wild;
  logic [wbps_pkg::LenW-1:0]  pat_len;
  logic [wbps_pkg::AddrW-1:0] base_addr;

  scan_result_t expected_results [$];
  int errors;
  int hits;
  int misses;

  function automatic scan_result_t scan_byte(input logic [7:0] b, input logic last);
    scan_result_t res;
    int unsigned  span;
    logic         ok;
    res = '0;
    span = (pat_len == 0) ? 1 :
           (pat_len > wbps_pkg::PatternBytes) ? wbps_pkg::PatternBytes : pat_len;
    for (int k = wbps_pkg::PatternBytes - 1; k > 0; k--) recent_bytes[k] = recent_bytes[k - 1];
    recent_bytes[0] = b;
    if (region_count != '1) region_count++;
    if (!found && region_count >= span) begin
      ok = 1'b1;
      for (int j = 0; j < span; j++)
        if (!wild[j] && recent_bytes[span - 1 - j] != pattern[8*j +: 8]) ok = 1'b0;
      if (ok) begin
        found = 1'b1;
        res.hit = 1'b1;
        res.offset = region_count - span;
        res.address = base_addr + wbps_pkg::AddrW'(res.offset);
      end
    end
    res.miss = last && !found;
    if (last) begin
      foreach (recent_bytes[k]) recent_bytes[k] = '0;
      region_count = '0;
      found = 1'b0;
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] scan mismatch: %s", $time, what);
    errors++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    scan_result_t want;
    scan_result_t got;
    if (!rst_ni) begin
      foreach (recent_bytes[k]) recent_bytes[k] = '0;
      region_count = '0;
      found = 1'b0;
      pattern = '0;
      wild = '0;
      pat_len = wbps_pkg::LenW'(1);
      base_addr = '0;
      expected_results.delete();
      errors = 0;
      hits = 0;
      misses = 0;
      outstanding_o <= 0;
      fail_count_o <= 0;
      hit_count_o <= 0;
      miss_count_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          wbps_pkg::RegPatternLow:    pattern[63:0] = cfg_data_i;
          wbps_pkg::RegPatternHigh:   pattern[127:64] = cfg_data_i;
          wbps_pkg::RegWildcardMask:  wild = cfg_data_i[wbps_pkg::MaskW-1:0];
          wbps_pkg::RegPatternLength: pat_len = cfg_data_i[wbps_pkg::LenW-1:0];
          wbps_pkg::RegBaseAddress:   base_addr = cfg_data_i[wbps_pkg::AddrW-1:0];
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result beat with no byte pending");
        end else begin
          want = expected_results.pop_front();
          got.hit = out_ch.hit;
          got.offset = out_ch.hit_offset;
          got.address = out_ch.hit_address;
          got.miss = out_ch.miss_at_end;
          if (got.hit !== want.hit)
            report_mismatch($sformatf("hit %b, expected %b", got.hit, want.hit));
          if (got.offset !== want.offset)
            report_mismatch($sformatf("hit_offset %h, expected %h", got.offset, want.offset));
          if (got.address !== want.address)
            report_mismatch($sformatf("hit_address %h, expected %h",
                                      got.address, want.address));
          if (got.miss !== want.miss)
            report_mismatch($sformatf("miss_at_end %b, expected %b", got.miss, want.miss));
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        want = scan_byte(in_ch.data_byte, in_ch.last_byte);
        if (want.hit) hits++;
        if (want.miss) misses++;
        // append at the tail, results leave in byte order
        expected_results = {expected_results, want};
      end
      outstanding_o <= expected_results.size();
      fail_count_o <= errors;
      hit_count_o <= hits;
      miss_count_o <= misses;
    end
  end

endmodule

// ===== dv/wildcard_byte_pattern_scanner_tb.sv =====
// testbench top: feeds byte regions and register writes to the scanner, checker scores
`timescale 1ns / 1ps
module wildcard_byte_pattern_scanner_tb;

  // index past the register file, the write must be dropped
  localparam logic [wbps_pkg::CfgIdxW-1:0] RegSpare = 3'd6;
  localparam int RandomBytes = 1000;
  localparam int PhaseBytes  = 75;
  localparam int IdlePct     = 27;

  logic                          clk_i = 1'b0;
  logic                          rst_ni;
  logic                          cfg_we_i;
  logic [wbps_pkg::CfgIdxW-1:0]  cfg_index_i;
  logic [wbps_pkg::CfgDataW-1:0] cfg_data_i;
  int outstanding;
  int fail_count;
  int hit_count;
  int miss_count;
  int bytes_sent;
  int settings;
  bit steady;

  wbps_in_if  in_ch();
  wbps_out_if out_ch();

  wildcard_byte_pattern_scanner DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  wbps_scan_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .outstanding_o (outstanding),
    .fail_count_o  (fail_count),
    .hit_count_o   (hit_count),
    .miss_count_o  (miss_count)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // result side back-pressure
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      out_ch.ready <= steady || ($urandom_range(99) >= IdlePct);
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    while (!steady && $urandom_range(99) < IdlePct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data_byte <= b;
    in_ch.last_byte <= last;
    do @(posedge clk_i); while (!in_ch.ready);
    bytes_sent++;
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    // result path is two stages deep
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [wbps_pkg::CfgIdxW-1:0] idx,
                           input logic [wbps_pkg::CfgDataW-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
  endtask

  task automatic load_config(input logic [63:0] lo, input logic [63:0] hi,
                             input logic [15:0] wild, input logic [4:0] plen,
                             input logic [47:0] base);
    write_reg(RegSpare, {$urandom, $urandom});
    write_reg(wbps_pkg::RegPatternLow, lo);
    write_reg(wbps_pkg::RegPatternHigh, hi);
    write_reg(wbps_pkg::RegWildcardMask, {48'd0, wild});
    write_reg(wbps_pkg::RegPatternLength, {59'd0, plen});
    write_reg(wbps_pkg::RegBaseAddress, {16'd0, base});
    cfg_we_i <= 1'b0;
    settings++;
  endtask

  // one region: mostly the pattern planted in noise drawn partly from its own bytes
  task automatic send_region(input logic [127:0] pat, input logic [15:0] wild,
                             input int unsigned span);
    logic [7:0]  region [48];
    int unsigned count;
    int unsigned start;
    if (span > 1 && $urandom_range(99) < 15) count = $urandom_range(span - 1, 1);
    else count = span + $urandom_range(30);
    for (int i = 0; i < count; i++)
      region[i] = $urandom_range(1) ? 8'($urandom_range(255)) : pat[8*$urandom_range(15) +: 8];
    if (count >= span && $urandom_range(99) < 70) begin
      start = 0;
      repeat ($urandom_range(2, 1)) begin
        start = $urandom_range(count - span);
        for (int j = 0; j < span; j++)
          if (!wild[j]) region[start + j] = pat[8*j +: 8];
      end
      // near miss: spoil one byte of the last copy
      if ($urandom_range(99) < 15) region[start + $urandom_range(span - 1)] ^= 8'h5a;
    end
    for (int i = 0; i < count; i++) send_byte(region[i], i == count - 1);
  endtask

  initial begin : stimulus
    logic [63:0] lo;
    logic [63:0] hi;
    logic [15:0] wild;
    logic [4:0]  plen;
    logic [47:0] base;
    int unsigned span;
    int          phase;
    int          phase_start;
    int          target;
    rst_ni <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.data_byte <= '0;
    in_ch.last_byte <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_index_i <= '0;
    cfg_data_i <= '0;
    steady <= 1'b0;
    bytes_sent = 0;
    settings = 1;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset pattern is a single zero byte
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(8'hff, 1'b1);
    wait_drained();

    // four bytes with a wildcard; base chosen so the address wraps to zero
    load_config(64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210, 16'h0002, 5'd4,
                48'hffff_ffff_fffe);
    send_byte(8'h11, 1'b0);
    send_byte(8'h22, 1'b0);
    send_byte(8'hef, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hab, 1'b0);
    send_byte(8'h89, 1'b1);
    send_byte(8'hef, 1'b1);
    wait_drained();

    // zero length behaves as one
    load_config(64'h0000_0000_0000_00ff, 64'h0, 16'h0000, 5'd0, 48'h0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b1);
    wait_drained();

    // oversized length clamps to sixteen, wildcards on both ends
    load_config(64'h0, 64'hffff_ffff_ffff_ffff, 16'h8001, 5'd31, 48'hffff_ffff_ffff);
    for (int j = 0; j < 16; j++)
      send_byte((j == 0 || j == 15) ? 8'($urandom_range(255)) : ((j < 8) ? 8'h00 : 8'hff),
                j == 15);
    wait_drained();

    target = bytes_sent + RandomBytes;
    for (phase = 0; bytes_sent < target; phase++) begin
      case ($urandom_range(9))
        0:       plen = 5'd0;
        1:       plen = 5'd16;
        2:       plen = 5'($urandom_range(31, 17));
        3:       plen = 5'd1;
        default: plen = 5'($urandom_range(8, 2));
      endcase
      case ($urandom_range(4))
        0: begin
          lo = '0;
          hi = '0;
        end
        1: begin
          lo = '1;
          hi = '1;
        end
        default: begin
          lo = {$urandom, $urandom};
          hi = {$urandom, $urandom};
        end
      endcase
      case ($urandom_range(9))
        0, 1, 2, 3: wild = 16'h0000;
        4:          wild = 16'hffff;
        default:    wild = 16'($urandom) & 16'($urandom);
      endcase
      case ($urandom_range(3))
        0:       base = '0;
        1:       base = '1;
        default: base = {16'($urandom), $urandom};
      endcase
      load_config(lo, hi, wild, plen, base);
      span = (plen == 0) ? 1 : (plen > 16) ? 16 : plen;
      steady <= (phase == 3);
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < PhaseBytes) send_region({hi, lo}, wild, span);
      wait_drained();
    end

    $display("scanned %0d bytes under %0d pattern settings, lengths 0 to 31 and wrapping bases",
             bytes_sent, settings);
    $display("regions gave %0d first matches and %0d misses at the end", hit_count, miss_count);
    if (fail_count == 0 && outstanding == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== wildcard_byte_pattern_scanner.f =====
hdl/wbps_pkg.sv
hdl/wbps_in_if.sv
hdl/wbps_out_if.sv
hdl/wbps_front.sv
hdl/wbps_queue.sv
hdl/wbps_back.sv
hdl/wildcard_byte_pattern_scanner.sv
dv/wbps_scan_checker.sv
dv/wildcard_byte_pattern_scanner_tb.sv
